FILE: rtl/core/srs_pkg.sv
package srs_pkg;

  localparam int FRACTION_BITS = 8;

  // field widths
  localparam int IN_W    = 16;
  localparam int TEMP_W  = 18;
  localparam int HUM_W   = 16;
  localparam int CNT_W   = 4;
  localparam int SHIFT_W = 3;
  localparam int CFG_W   = 4;
  localparam int IDX_W   = 1;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_ERROR_LIMIT     = 1'd0;
  localparam logic [IDX_W-1:0] CFG_SMOOTHING_SHIFT = 1'd1;

  localparam logic [CNT_W-1:0]   ERROR_LIMIT_RST     = 4'd3;
  localparam logic [SHIFT_W-1:0] SMOOTHING_SHIFT_RST = 3'd2;

  localparam int TEMP_MAX = 2 ** (TEMP_W - 1) - 1;
  localparam int TEMP_MIN = -(2 ** (TEMP_W - 1));

  // 32 degrees F in fixed point
  localparam int F_OFFSET = 32 << FRACTION_BITS;

  // floor(9c / 5): bias 9c to non-negative by 5*DIV_K, then reciprocal multiply
  localparam int MUL_W       = IN_W + 4;
  localparam int DIV_K       = (9 * (2 ** (IN_W - 1)) + 4) / 5;
  localparam int DIV_BIAS    = 5 * DIV_K;
  localparam int RECIP_SHIFT = MUL_W + 2;
  localparam int RECIP       = (2 ** RECIP_SHIFT) / 5 + 1;
  localparam int QUO_W       = 2 * MUL_W - RECIP_SHIFT;
  localparam int F_ADJ       = F_OFFSET - DIV_K;

endpackage

FILE: rtl/core/sensor_reading_smoother_core.sv
// Path: input register, then state registers. Throughput: one word per cycle while
//   out_stall is low; the input register and the result register each hold one word, so
//   one more word is taken while a finished result waits behind out_stall.
// Reset (rst, synchronous, active high): error run, seed and availability cleared, averages
//   zero, error_limit = 3, smoothing_shift = 2, both word registers empty.
module sensor_reading_smoother_core
  import srs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_write,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     read_ok,
  input  logic signed [IN_W-1:0]   temp_celsius,
  input  logic signed [IN_W-1:0]   humidity_raw,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     valid_flag,
  output logic signed [TEMP_W-1:0] temp_fahrenheit,
  output logic signed [HUM_W-1:0]  humidity_smoothed,
  output logic [CNT_W-1:0]         failure_count
);

  localparam int FW = TEMP_W + 2;
  localparam logic signed [FW-1:0] F_ADJ_S    = FW'(F_ADJ);
  localparam logic signed [FW-1:0] T_MAX_S    = FW'(TEMP_MAX);
  localparam logic signed [FW-1:0] T_MIN_S    = FW'(TEMP_MIN);
  localparam logic [MUL_W-1:0]     DIV_BIAS_U = MUL_W'(DIV_BIAS);
  localparam logic [MUL_W-1:0]     RECIP_U    = MUL_W'(RECIP);

  // configuration registers
  logic [CNT_W-1:0]   error_limit;
  logic [SHIFT_W-1:0] smoothing_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_limit     <= ERROR_LIMIT_RST;
      smoothing_shift <= SMOOTHING_SHIFT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ERROR_LIMIT:     error_limit     <= cfg_data;
        CFG_SMOOTHING_SHIFT: smoothing_shift <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. The input register advances into the result stage whenever the
  // result register is empty or being taken in this cycle.
  // ---------------------------------------------------------------------------
  logic                   in_full;
  logic                   r_ok;
  logic signed [IN_W-1:0] r_temp;
  logic signed [IN_W-1:0] r_hum;
  logic                   advance;
  logic                   in_fire;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_full   <= in_fire || (in_full && !advance);
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      r_ok   <= read_ok;
      r_temp <= temp_celsius;
      r_hum  <= humidity_raw;
    end
  end

  // ---------------------------------------------------------------------------
  // Celsius to Fahrenheit: floor(9c/5) + 32.
  // 9c is biased by 5*DIV_K so the divide sees a non-negative numerator;
  // DIV_K comes back out together with the 32 degree offset.
  // ---------------------------------------------------------------------------
  logic signed [MUL_W-1:0] c_ext;
  logic signed [MUL_W-1:0] temp9;
  logic [MUL_W-1:0]        div_num;
  logic [2*MUL_W-1:0]      div_prod;
  logic [QUO_W-1:0]        div_quo;
  logic signed [FW-1:0]    fahr_wide;
  logic signed [TEMP_W-1:0] fahr;

  always_comb begin
    c_ext     = MUL_W'(r_temp);
    temp9     = (c_ext <<< 3) + c_ext;
    div_num   = $unsigned(temp9) + DIV_BIAS_U;
    div_prod  = div_num * RECIP_U;
    div_quo   = div_prod[2*MUL_W-1:RECIP_SHIFT];
    fahr_wide = $signed({{(FW-QUO_W){1'b0}}, div_quo}) + F_ADJ_S;
    if (fahr_wide > T_MAX_S)      fahr = TEMP_MAX[TEMP_W-1:0];
    else if (fahr_wide < T_MIN_S) fahr = TEMP_MIN[TEMP_W-1:0];
    else                          fahr = fahr_wide[TEMP_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // State. The result word is the state after the step, so the state
  // registers double as the result payload; they only move on advance.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]         error_run,        error_run_next;
  logic                     seeded,           seeded_next;
  logic                     available,        available_next;
  logic signed [TEMP_W-1:0] temp_average,     temp_average_next;
  logic signed [HUM_W-1:0]  humidity_average, humidity_average_next;

  logic signed [TEMP_W:0]   t_diff;
  logic signed [TEMP_W:0]   t_step;
  logic signed [HUM_W:0]    h_diff;
  logic signed [HUM_W:0]    h_step;

  always_comb begin
    // average moves by the difference, arithmetic shift (floor)
    t_diff = {fahr[TEMP_W-1], fahr} - {temp_average[TEMP_W-1], temp_average};
    t_step = t_diff >>> smoothing_shift;
    h_diff = {r_hum[HUM_W-1], r_hum} - {humidity_average[HUM_W-1], humidity_average};
    h_step = h_diff >>> smoothing_shift;

    error_run_next        = error_run;
    seeded_next           = seeded;
    available_next        = available;
    temp_average_next     = temp_average;
    humidity_average_next = humidity_average;

    if (!r_ok) begin
      // counter saturates at the limit; a lowered limit just stops it
      if (error_run < error_limit) error_run_next = error_run + 1'b1;
      if (error_run_next >= error_limit && available) begin
        available_next = 1'b0;
        seeded_next    = 1'b0;
      end
    end else begin
      error_run_next = '0;
      if (!seeded) begin
        temp_average_next     = fahr;
        humidity_average_next = r_hum;
      end else begin
        temp_average_next     = temp_average + t_step[TEMP_W-1:0];
        humidity_average_next = humidity_average + h_step[HUM_W-1:0];
      end
      seeded_next    = 1'b1;
      available_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_run        <= '0;
      seeded           <= 1'b0;
      available        <= 1'b0;
      temp_average     <= '0;
      humidity_average <= '0;
    end else if (advance) begin
      error_run        <= error_run_next;
      seeded           <= seeded_next;
      available        <= available_next;
      temp_average     <= temp_average_next;
      humidity_average <= humidity_average_next;
    end
  end

  assign valid_flag        = available;
  assign temp_fahrenheit   = temp_average;
  assign humidity_smoothed = humidity_average;
  assign failure_count     = error_run;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_seed_tracks_avail: assert property (@(posedge clk) disable iff (rst)
    seeded == available)
    else $error("seed and availability disagree");

  a_good_read: assert property (@(posedge clk) disable iff (rst)
    (advance && r_ok) |=> (valid_flag && failure_count == '0 && out_valid))
    else $error("good read did not clear the run and claim the values");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(temp_fahrenheit) && $stable(humidity_smoothed)
                  && $stable(failure_count) && $stable(valid_flag)))
    else $error("result changed without a step");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && out_valid && out_stall))
    else $error("input stalled with room to move");

endmodule
